### rtl/core/frp_pkg.sv
// ----------------------------------------------------------------------------
// frp_pkg
// Shared types and constants for the FTP reply recognizer.
// ----------------------------------------------------------------------------
package frp_pkg;

   localparam logic [7:0]  DASH_CHAR    = 8'h2D;
   localparam logic [7:0]  SPACE_CHAR   = 8'h20;
   localparam logic [7:0]  NEWLINE_CHAR = 8'h0A;
   localparam logic [15:0] LIMIT_RESET  = 16'd2048;
   localparam logic [16:0] COUNT_MAX    = 17'h1FFFF;

   // reply phase codes; code 3 behaves as PHASE_CODE
   localparam logic [1:0] PHASE_CODE   = 2'd0;
   localparam logic [1:0] PHASE_SINGLE = 2'd1;
   localparam logic [1:0] PHASE_MULTI  = 2'd2;

   localparam logic STATUS_DONE     = 1'b0;
   localparam logic STATUS_OVERFLOW = 1'b1;

   typedef struct packed {
      logic [23:0] code_word;
      logic        reply_status;
      logic        was_multi_line;
   } frp_result_type;

endpackage

### rtl/core/frp_if.sv
// ----------------------------------------------------------------------------
// frp_byte_if / frp_reply_if
// Valid/ready channels for received bytes and recognized replies.
// ----------------------------------------------------------------------------
interface frp_byte_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface frp_reply_if;
   logic        valid;
   logic        ready;
   logic [23:0] code_word;
   logic        reply_status;
   logic        was_multi_line;

   modport source (output valid, output code_word, output reply_status,
                   output was_multi_line, input ready);
   modport sink (input valid, input code_word, input reply_status,
                 input was_multi_line, output ready);
endinterface

### rtl/core/frp_parser.sv
// ----------------------------------------------------------------------------
// frp_parser
// Per-byte reply state and its next-state logic. One byte per step.
// ----------------------------------------------------------------------------
module frp_parser (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic [7:0]              ch,
   input  logic [15:0]             max_bytes,
   output logic                    emit,
   output frp_pkg::frp_result_type result
);
   import frp_pkg::*;

   logic [1:0]  phase_ff, phase_in;
   logic [1:0]  header_pos_ff, header_pos_in;
   logic [23:0] code_ff, code_in;
   logic [23:0] line_chars_ff, line_chars_in;
   logic [2:0]  line_pos_ff, line_pos_in;
   logic [16:0] body_ff, body_in;
   logic        last_ff, last_in;
   logic [16:0] count_inc;
   logic        status;

   assign count_inc = (body_ff != COUNT_MAX) ? body_ff + 17'd1 : body_ff;

   always_comb begin
      phase_in      = phase_ff;
      header_pos_in = header_pos_ff;
      code_in       = code_ff;
      line_chars_in = line_chars_ff;
      line_pos_in   = line_pos_ff;
      body_in       = body_ff;
      last_in       = last_ff;
      emit          = 1'b0;
      status        = STATUS_DONE;
      if (step) begin
         if (phase_ff != PHASE_SINGLE && phase_ff != PHASE_MULTI) begin
            phase_in = PHASE_CODE;
            if (header_pos_ff != 2'd3) begin
               code_in       = {code_ff[15:0], ch};
               header_pos_in = header_pos_ff + 2'd1;
            end else begin
               phase_in      = (ch == DASH_CHAR) ? PHASE_MULTI : PHASE_SINGLE;
               header_pos_in = 2'd0;
               line_pos_in   = 3'd0;
               line_chars_in = 24'd0;
               body_in       = 17'd0;
               last_in       = 1'b0;
            end
         end else begin
            body_in = count_inc;
            // limit check comes before the byte is interpreted
            if (count_inc > {1'b0, max_bytes}) begin
               emit   = 1'b1;
               status = STATUS_OVERFLOW;
            end else if (phase_ff == PHASE_SINGLE) begin
               emit = (ch == NEWLINE_CHAR);
            end else if (ch == NEWLINE_CHAR) begin
               if (last_ff) emit = 1'b1;
               else line_pos_in = 3'd0;
            end else begin
               unique case (line_pos_ff)
                  3'd0: line_chars_in[23:16] = ch;
                  3'd1: line_chars_in[15:8]  = ch;
                  3'd2: line_chars_in[7:0]   = ch;
                  3'd3: last_in = (ch == SPACE_CHAR) && (line_chars_ff == code_ff);
                  default: ;
               endcase
               if (line_pos_ff < 3'd4) line_pos_in = line_pos_ff + 3'd1;
            end
         end
         if (emit) begin
            phase_in      = PHASE_CODE;
            header_pos_in = 2'd0;
            code_in       = 24'd0;
            line_chars_in = 24'd0;
            line_pos_in   = 3'd0;
            body_in       = 17'd0;
            last_in       = 1'b0;
         end
      end
   end

   assign result.code_word      = code_ff;
   assign result.reply_status   = status;
   assign result.was_multi_line = (phase_ff == PHASE_MULTI);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PHASE_CODE;
         header_pos_ff <= 2'd0;
         code_ff       <= 24'd0;
         line_chars_ff <= 24'd0;
         line_pos_ff   <= 3'd0;
         body_ff       <= 17'd0;
         last_ff       <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         header_pos_ff <= header_pos_in;
         code_ff       <= code_in;
         line_chars_ff <= line_chars_in;
         line_pos_ff   <= line_pos_in;
         body_ff       <= body_in;
         last_ff       <= last_in;
      end
   end

endmodule

### rtl/core/ftp_reply_recognizer.sv
// ----------------------------------------------------------------------------
// ftp_reply_recognizer
// Recognizes single-line and multi-line FTP control replies from a byte stream.
// ----------------------------------------------------------------------------
// A reply reaches rsp through the input register and then the result register.
// Throughput: one byte per cycle while no reply waits unaccepted on rsp, set by
// the single-pass parser between the input register and the result register.
// Stalls: the input holds while a reply waits unaccepted on rsp.
// Reset: synchronous; clears parser state, empties both registers and loads the
// byte limit with 2048.
module ftp_reply_recognizer (
   input  logic               clock,
   input  logic               reset,
   frp_byte_if.sink           req,
   frp_reply_if.source        rsp,
   input  logic               csr_wr_en,
   input  logic [15:0]        csr_wr_data
);
   import frp_pkg::*;

   logic           in_valid_ff;
   logic [7:0]     in_byte_ff;
   logic           rsp_valid_ff;
   frp_result_type rsp_data_ff;
   logic [15:0]    max_ff;
   logic           advance;
   logic           emit;
   frp_result_type result;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;

   frp_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .ch        (in_byte_ff),
      .max_bytes (max_ff),
      .emit      (emit),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         max_ff       <= LIMIT_RESET;
      end else begin
         if (req.valid && req.ready) in_valid_ff <= 1'b1;
         else if (advance) in_valid_ff <= 1'b0;
         if (advance && emit) rsp_valid_ff <= 1'b1;
         else if (rsp.ready) rsp_valid_ff <= 1'b0;
         if (csr_wr_en) max_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) in_byte_ff <= req.rx_byte;
      if (advance && emit) rsp_data_ff <= result;
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.code_word      = rsp_data_ff.code_word;
   assign rsp.reply_status   = rsp_data_ff.reply_status;
   assign rsp.was_multi_line = rsp_data_ff.was_multi_line;

endmodule

### rtl/core/frp_checker.sv
// ----------------------------------------------------------------------------
// frp_checker
// Port-level checks for the FTP reply recognizer, bound to the top level.
// ----------------------------------------------------------------------------
module frp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [23:0] rsp_code_word,
   input logic        rsp_reply_status,
   input logic        rsp_was_multi_line
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_code_word)
         && $stable(rsp_reply_status) && $stable(rsp_was_multi_line))
      else $error("stalled reply changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("reply valid after reset");

   // a new reply needs a byte accepted on req, which passes the input register first
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("reply without a causing byte");

   // input only stalls behind a stalled reply
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without output backpressure");

endmodule

bind ftp_reply_recognizer frp_checker u_frp_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req.valid),
   .req_ready          (req.ready),
   .rsp_valid          (rsp.valid),
   .rsp_ready          (rsp.ready),
   .rsp_code_word      (rsp.code_word),
   .rsp_reply_status   (rsp.reply_status),
   .rsp_was_multi_line (rsp.was_multi_line)
);
